// ===== rtl/mmc_pkg.sv =====
`default_nettype none

package mmc_pkg;

   localparam int MEM_ADDR_BITS = 16;
   localparam int MEM_WORDS     = 1 << MEM_ADDR_BITS;
   localparam int WORD_W        = 16;
   localparam int COUNT_W       = 32;

   typedef logic [WORD_W-1:0] word_type;

   typedef enum logic [1:0] {
      MODE_WRITE = 2'd0,
      MODE_EXEC  = 2'd1,
      MODE_READ  = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      SRC_A      = 4'd0,
      SRC_B      = 4'd1,
      SRC_ADD    = 4'd2,
      SRC_AND    = 4'd3,
      SRC_OR     = 4'd4,
      SRC_XOR    = 4'd5,
      SRC_SHR    = 4'd6,
      SRC_LIT    = 4'd7,
      SRC_CP     = 4'd8,
      SRC_MCP    = 4'd9,
      SRC_MCP_DEC = 4'd10,
      SRC_MCP_INC = 4'd11,
      SRC_DP     = 4'd12,
      SRC_MDP    = 4'd13,
      SRC_DEC_MDP = 4'd14,
      SRC_INC_MDP = 4'd15
   } src_type;

   typedef enum logic [3:0] {
      DST_A       = 4'd0,
      DST_B       = 4'd1,
      DST_PC      = 4'd2,
      DST_PC_Z    = 4'd3,
      DST_PC_NZ   = 4'd4,
      DST_PC_C    = 4'd5,
      DST_PC_MCPZ = 4'd6,
      DST_PC_MDPZ = 4'd7,
      DST_CP      = 4'd8,
      DST_MCP     = 4'd9,
      DST_INC_MCP = 4'd10,
      DST_DEC_MCP = 4'd11,
      DST_DP      = 4'd12,
      DST_MDP     = 4'd13,
      DST_MDP_INC = 4'd14,
      DST_MDP_DEC = 4'd15
   } dst_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SRC,
      ST_DST,
      ST_COND,
      ST_RDWORD,
      ST_DONE
   } state_type;

   // register-side results of the operand unit
   typedef struct packed {
      word_type value;
      logic     is_mem;
      logic     jump_take;
   } alu_out_type;

endpackage

`default_nettype wire

// ===== rtl/mmc_ram.sv =====
`default_nettype none

module mmc_ram
   import mmc_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic                     re,
   input  wire logic [MEM_ADDR_BITS-1:0] addr,
   input  wire word_type                 wdata,
   output word_type                      rdata
);

   word_type mem_array [MEM_WORDS];
   word_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_array[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_array[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== rtl/mmc_alu.sv =====
`default_nettype none

module mmc_alu
   import mmc_pkg::*;
(
   input  wire word_type acc_a,
   input  wire word_type acc_b,
   input  wire word_type ptr_c,
   input  wire word_type ptr_d,
   input  wire src_type  src,
   input  wire dst_type  dst,
   output alu_out_type   result
);

   logic [WORD_W:0] sum;

   assign sum = {1'b0, acc_a} + {1'b0, acc_b};

   always_comb begin
      result.value     = '0;
      result.is_mem    = 1'b0;
      result.jump_take = 1'b0;
      unique case (src)
         SRC_A:   result.value = acc_a;
         SRC_B:   result.value = acc_b;
         SRC_ADD: result.value = sum[WORD_W-1:0];
         SRC_AND: result.value = acc_a & acc_b;
         SRC_OR:  result.value = acc_a | acc_b;
         SRC_XOR: result.value = acc_a ^ acc_b;
         SRC_SHR: result.value = acc_a >> 1;
         SRC_CP:  result.value = ptr_c;
         SRC_DP:  result.value = ptr_d;
         SRC_LIT, SRC_MCP, SRC_MCP_DEC, SRC_MCP_INC,
         SRC_MDP, SRC_DEC_MDP, SRC_INC_MDP: result.is_mem = 1'b1;
      endcase

      // register-only jump conditions; memory tests are resolved by the sequencer
      unique case (dst)
         DST_PC:    result.jump_take = 1'b1;
         DST_PC_Z:  result.jump_take = (sum == '0);
         DST_PC_NZ: result.jump_take = (sum != '0);
         DST_PC_C:  result.jump_take = sum[WORD_W];
         default:   result.jump_take = 1'b0;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/move_machine_cpu_core.sv =====
`default_nettype none

// Move-only 16-bit processor with a private word memory of 2**MEM_ADDR_BITS
// words behind a single synchronous port (one access per cycle, registered
// read data). A request in mode 0 writes memory and mode 3 does nothing; mode
// 2 reads a memory word; mode 1 runs one instruction: fetch, then two moves,
// each a source step and a destination step, plus a memory-test step for
// each move whose destination tests a memory word. Every request ends in a
// done step that loads the response slot once it is free; the core then
// returns to idle and takes the next request. Fetch, operand reads and stores
// are serialized on the single memory port. Each request yields one response
// carrying the registers after the request; an output register lets the core
// return to idle while that response waits. Memory is undefined until written
// and gets no clearing pass.

module move_machine_cpu_core
   import mmc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,

   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [1:0]          req_mode,
   input  wire logic [15:0]         req_addr,
   input  wire logic [15:0]         req_data,

   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [15:0]              rsp_prog_counter,
   output logic [15:0]              rsp_acc_a,
   output logic [15:0]              rsp_acc_b,
   output logic [15:0]              rsp_ptr_c,
   output logic [15:0]              rsp_ptr_d,
   output logic [31:0]              rsp_move_total,
   output logic [15:0]              rsp_read_word
);

   state_type state_ff, state_in;

   // architectural registers
   word_type pc_ff, pc_in;
   word_type a_ff, a_in;
   word_type b_ff, b_in;
   word_type cp_ff, cp_in;
   word_type dp_ff, dp_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   // sequencer working registers
   word_type ir_ff, ir_in;
   word_type val_ff, val_in;
   word_type rd_ff, rd_in;
   logic     src_mem_ff, src_mem_in;
   logic     move_sel_ff, move_sel_in;

   // response slot
   logic               rsp_valid_ff, rsp_valid_in;
   word_type           o_pc_ff, o_pc_in;
   word_type           o_a_ff, o_a_in;
   word_type           o_b_ff, o_b_in;
   word_type           o_cp_ff, o_cp_in;
   word_type           o_dp_ff, o_dp_in;
   logic [COUNT_W-1:0] o_count_ff, o_count_in;
   word_type           o_rd_ff, o_rd_in;

   // memory port
   logic     mem_we, mem_re;
   word_type mem_addr, mem_wdata, mem_rdata;

   mode_type    mode;
   src_type     cur_src;
   dst_type     cur_dst;
   alu_out_type alu;
   word_type    move_val;
   logic        dst_is_test;
   logic        slot_free;

   assign mode        = mode_type'(req_mode);
   assign cur_src     = src_type'(move_sel_ff ? ir_ff[3:0] : ir_ff[11:8]);
   assign cur_dst     = dst_type'(move_sel_ff ? ir_ff[7:4] : ir_ff[15:12]);
   assign move_val    = src_mem_ff ? mem_rdata : val_ff;
   assign dst_is_test = (cur_dst == DST_PC_MCPZ) || (cur_dst == DST_PC_MDPZ);
   assign slot_free   = !rsp_valid_ff || rsp_ready;

   mmc_ram u_ram (
      .clock (clock),
      .we    (mem_we),
      .re    (mem_re),
      .addr  (mem_addr[MEM_ADDR_BITS-1:0]),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   mmc_alu u_alu (
      .acc_a  (a_ff),
      .acc_b  (b_ff),
      .ptr_c  (cp_ff),
      .ptr_d  (dp_ff),
      .src    (cur_src),
      .dst    (cur_dst),
      .result (alu)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (mode)
                  MODE_EXEC: state_in = ST_FETCH;
                  MODE_READ: state_in = ST_RDWORD;
                  MODE_WRITE, MODE_NONE: state_in = ST_DONE;
               endcase
            end
         end
         ST_FETCH:  state_in = ST_SRC;
         ST_SRC:    state_in = ST_DST;
         ST_DST: begin
            if (dst_is_test) begin
               state_in = ST_COND;
            end else begin
               state_in = move_sel_ff ? ST_DONE : ST_SRC;
            end
         end
         ST_COND:   state_in = move_sel_ff ? ST_DONE : ST_SRC;
         ST_RDWORD: state_in = ST_DONE;
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      pc_in       = pc_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      cp_in       = cp_ff;
      dp_in       = dp_ff;
      count_in    = count_ff;
      ir_in       = ir_ff;
      val_in      = val_ff;
      rd_in       = rd_ff;
      src_mem_in  = src_mem_ff;
      move_sel_in = move_sel_ff;
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      mem_addr    = '0;
      mem_wdata   = move_val;
      req_ready   = 1'b0;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      o_pc_in      = o_pc_ff;
      o_a_in       = o_a_ff;
      o_b_in       = o_b_ff;
      o_cp_in      = o_cp_ff;
      o_dp_in      = o_dp_ff;
      o_count_in   = o_count_ff;
      o_rd_in      = o_rd_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               rd_in = '0;
               unique case (mode)
                  MODE_WRITE: begin
                     mem_we    = 1'b1;
                     mem_addr  = req_addr;
                     mem_wdata = req_data;
                  end
                  MODE_EXEC: begin
                     mem_re   = 1'b1;
                     mem_addr = pc_ff;
                  end
                  MODE_READ: begin
                     mem_re   = 1'b1;
                     mem_addr = req_addr;
                  end
                  MODE_NONE: ;
               endcase
            end
         end

         ST_FETCH: begin
            ir_in       = mem_rdata;
            pc_in       = pc_ff + 16'd1;
            move_sel_in = 1'b0;
         end

         // source read: issue the memory read, apply pointer side effects
         ST_SRC: begin
            count_in   = count_ff + 32'd1;
            src_mem_in = alu.is_mem;
            val_in     = alu.value;
            mem_re     = alu.is_mem;
            unique case (cur_src)
               SRC_LIT: begin
                  mem_addr = pc_ff;
                  pc_in    = pc_ff + 16'd1;
               end
               SRC_MCP:     mem_addr = cp_ff;
               SRC_MCP_DEC: begin
                  mem_addr = cp_ff;
                  cp_in    = cp_ff - 16'd1;
               end
               SRC_MCP_INC: begin
                  mem_addr = cp_ff;
                  cp_in    = cp_ff + 16'd1;
               end
               SRC_MDP:     mem_addr = dp_ff;
               SRC_DEC_MDP: begin
                  mem_addr = dp_ff - 16'd1;
                  dp_in    = dp_ff - 16'd1;
               end
               SRC_INC_MDP: begin
                  mem_addr = dp_ff + 16'd1;
                  dp_in    = dp_ff + 16'd1;
               end
               default: ;
            endcase
         end

         // destination write
         ST_DST: begin
            val_in = move_val;
            if (!dst_is_test) begin
               move_sel_in = 1'b1;
            end
            unique case (cur_dst)
               DST_A: a_in = move_val;
               DST_B: b_in = move_val;
               DST_PC, DST_PC_Z, DST_PC_NZ, DST_PC_C: begin
                  if (alu.jump_take) begin
                     pc_in = move_val;
                  end
               end
               DST_PC_MCPZ: begin
                  mem_re   = 1'b1;
                  mem_addr = cp_ff;
               end
               DST_PC_MDPZ: begin
                  mem_re   = 1'b1;
                  mem_addr = dp_ff;
               end
               DST_CP: cp_in = move_val;
               DST_MCP: begin
                  mem_we   = 1'b1;
                  mem_addr = cp_ff;
               end
               DST_INC_MCP: begin
                  mem_we   = 1'b1;
                  mem_addr = cp_ff + 16'd1;
                  cp_in    = cp_ff + 16'd1;
               end
               DST_DEC_MCP: begin
                  mem_we   = 1'b1;
                  mem_addr = cp_ff - 16'd1;
                  cp_in    = cp_ff - 16'd1;
               end
               DST_DP: dp_in = move_val;
               DST_MDP: begin
                  mem_we   = 1'b1;
                  mem_addr = dp_ff;
               end
               DST_MDP_INC: begin
                  mem_we   = 1'b1;
                  mem_addr = dp_ff;
                  dp_in    = dp_ff + 16'd1;
               end
               DST_MDP_DEC: begin
                  mem_we   = 1'b1;
                  mem_addr = dp_ff;
                  dp_in    = dp_ff - 16'd1;
               end
            endcase
         end

         // memory-word test jump: the word read back decides
         ST_COND: begin
            move_sel_in = 1'b1;
            if (mem_rdata == '0) begin
               pc_in = val_ff;
            end
         end

         ST_RDWORD: rd_in = mem_rdata;

         // hold until the response slot frees up, then load it
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               o_pc_in      = pc_ff;
               o_a_in       = a_ff;
               o_b_in       = b_ff;
               o_cp_in      = cp_ff;
               o_dp_in      = dp_ff;
               o_count_in   = count_ff;
               o_rd_in      = rd_ff;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         a_ff         <= '0;
         b_ff         <= '0;
         cp_ff        <= '0;
         dp_ff        <= '0;
         count_ff     <= '0;
         ir_ff        <= '0;
         move_sel_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         a_ff         <= a_in;
         b_ff         <= b_in;
         cp_ff        <= cp_in;
         dp_ff        <= dp_in;
         count_ff     <= count_in;
         ir_ff        <= ir_in;
         move_sel_ff  <= move_sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff      <= val_in;
      rd_ff       <= rd_in;
      src_mem_ff  <= src_mem_in;
      o_pc_ff     <= o_pc_in;
      o_a_ff      <= o_a_in;
      o_b_ff      <= o_b_in;
      o_cp_ff     <= o_cp_in;
      o_dp_ff     <= o_dp_in;
      o_count_ff  <= o_count_in;
      o_rd_ff     <= o_rd_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_prog_counter = o_pc_ff;
   assign rsp_acc_a        = o_a_ff;
   assign rsp_acc_b        = o_b_ff;
   assign rsp_ptr_c        = o_cp_ff;
   assign rsp_ptr_d        = o_dp_ff;
   assign rsp_move_total   = o_count_ff;
   assign rsp_read_word    = o_rd_ff;

   // the move counter only advances while a source is read
   a_count_src_only: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_SRC) |=> $stable(count_ff))
      else $error("move counter changed outside a source step");

   // stores happen only for a write request or a destination step
   a_store_place: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> ((state_ff == ST_IDLE) || (state_ff == ST_DST)))
      else $error("memory write outside write request or destination step");

   // a memory test always follows the destination step that issued its read
   a_cond_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COND) |-> ($past(state_ff) == ST_DST))
      else $error("memory test step entered out of order");

   // the port never reads and writes in the same cycle
   a_one_access: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("memory read and write in the same cycle");

endmodule

`default_nettype wire
